// ===== sv/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared item types, phase encoding, magic words and result codes.
// ----------------------------------------------------------------------------
package whp_pkg;

   // Magic words as they read after little-endian assembly of four bytes
   localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
   localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
   localparam logic [31:0] MAGIC_FMT  = 32'h2074_6D66;
   localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   typedef enum logic [3:0] {
      PH_RIFF    = 4'd0,
      PH_FSIZE   = 4'd1,
      PH_WAVE    = 4'd2,
      PH_FMTID   = 4'd3,
      PH_FMTLEN  = 4'd4,
      PH_FMTBODY = 4'd5,
      PH_CKID    = 4'd6,
      PH_CKLEN   = 4'd7,
      PH_SKIP    = 4'd8,
      PH_DATA    = 4'd9,
      PH_DONE    = 4'd10,
      PH_ERROR   = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FORMAT = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_BAD_RIFF  = 3'd0,
      ERR_BAD_WAVE  = 3'd1,
      ERR_BAD_FMT   = 3'd2,
      ERR_FMT_SHORT = 3'd3,
      ERR_EARLY_END = 3'd4
   } error_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] sample_bits;
      logic [31:0] payload_size;
      logic [2:0]  error_code;
   } rsp_item_type;

endpackage

// ===== sv/whp_ifs.sv =====
// ----------------------------------------------------------------------------
// WAV header parser channels
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic        last_payload;
   logic [15:0] audio_format;
   logic [15:0] channel_count;
   logic [31:0] sample_rate;
   logic [31:0] byte_rate;
   logic [15:0] sample_bits;
   logic [31:0] payload_size;
   logic [2:0]  error_code;

   modport source (
      output valid, output kind, output payload_byte, output last_payload,
      output audio_format, output channel_count, output sample_rate,
      output byte_rate, output sample_bits, output payload_size,
      output error_code, input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input last_payload,
      input audio_format, input channel_count, input sample_rate,
      input byte_rate, input sample_bits, input payload_size,
      input error_code, output ready
   );
endinterface

// ===== sv/whp_in_stage.sv =====
// ----------------------------------------------------------------------------
// WAV header parser input register
// Holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
module whp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   whp_req_if.sink               req_chan,
   input  logic                  advance,
   output logic                  item_valid,
   output whp_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   whp_pkg::req_item_type item_ff;
   logic                  take;

   // accept when empty or when the held item moves on this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte     <= req_chan.data_byte;
         item_ff.end_of_stream <= req_chan.end_of_stream;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/whp_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header parser core
// Parse state and the per-byte step; emits at most one result per byte.
// ----------------------------------------------------------------------------
module whp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  whp_pkg::req_item_type item,
   output logic                  result_valid,
   output whp_pkg::rsp_item_type result
);

   whp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] fmt_len_ff, fmt_len_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] byte_rate_ff, byte_rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        is_data_ff, is_data_in;

   logic [7:0]  b;
   logic [31:0] word;
   logic        word_done;
   logic [31:0] cnt_inc;
   logic [31:0] cnt_dec;

   assign b         = item.data_byte;
   assign word      = {b, shift_ff[23:0]};
   assign word_done = (cnt_ff[1:0] == 2'd3);
   assign cnt_inc   = cnt_ff + 32'd1;
   assign cnt_dec   = cnt_ff - 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      fmt_len_in   = fmt_len_ff;
      format_in    = format_ff;
      channels_in  = channels_ff;
      rate_in      = rate_ff;
      byte_rate_in = byte_rate_ff;
      bits_in      = bits_ff;
      is_data_in   = is_data_ff;
      result_valid = 1'b0;
      result       = '0;

      // word phases: drop the byte into its lane, advance the count
      unique case (phase_ff)
         whp_pkg::PH_RIFF, whp_pkg::PH_FSIZE, whp_pkg::PH_WAVE,
         whp_pkg::PH_FMTID, whp_pkg::PH_FMTLEN, whp_pkg::PH_CKID,
         whp_pkg::PH_CKLEN: begin
            shift_in[8*cnt_ff[1:0] +: 8] = b;
            cnt_in = cnt_inc;
         end
         default: begin
         end
      endcase

      unique case (phase_ff)
         whp_pkg::PH_RIFF: begin
            if (word_done) begin
               if (word != whp_pkg::MAGIC_RIFF) begin
                  result_valid      = 1'b1;
                  result.kind       = whp_pkg::KIND_ERROR;
                  result.error_code = whp_pkg::ERR_BAD_RIFF;
                  phase_in          = whp_pkg::PH_ERROR;
               end else begin
                  phase_in = whp_pkg::PH_FSIZE;
                  cnt_in   = '0;
                  shift_in = '0;
               end
            end
         end
         whp_pkg::PH_FSIZE: begin
            if (word_done) begin
               phase_in = whp_pkg::PH_WAVE;
               cnt_in   = '0;
               shift_in = '0;
            end
         end
         whp_pkg::PH_WAVE: begin
            if (word_done) begin
               if (word != whp_pkg::MAGIC_WAVE) begin
                  result_valid      = 1'b1;
                  result.kind       = whp_pkg::KIND_ERROR;
                  result.error_code = whp_pkg::ERR_BAD_WAVE;
                  phase_in          = whp_pkg::PH_ERROR;
               end else begin
                  phase_in = whp_pkg::PH_FMTID;
                  cnt_in   = '0;
                  shift_in = '0;
               end
            end
         end
         whp_pkg::PH_FMTID: begin
            if (word_done) begin
               if (word != whp_pkg::MAGIC_FMT) begin
                  result_valid      = 1'b1;
                  result.kind       = whp_pkg::KIND_ERROR;
                  result.error_code = whp_pkg::ERR_BAD_FMT;
                  phase_in          = whp_pkg::PH_ERROR;
               end else begin
                  phase_in = whp_pkg::PH_FMTLEN;
                  cnt_in   = '0;
                  shift_in = '0;
               end
            end
         end
         whp_pkg::PH_FMTLEN: begin
            if (word_done) begin
               fmt_len_in = word;
               if (word < whp_pkg::FMT_MIN_LEN) begin
                  result_valid      = 1'b1;
                  result.kind       = whp_pkg::KIND_ERROR;
                  result.error_code = whp_pkg::ERR_FMT_SHORT;
                  phase_in          = whp_pkg::PH_ERROR;
               end else begin
                  phase_in = whp_pkg::PH_FMTBODY;
                  cnt_in   = '0;
                  shift_in = '0;
               end
            end
         end
         whp_pkg::PH_FMTBODY: begin
            // fixed 16-byte layout; block align and any extension bytes drop out
            if (cnt_ff[31:4] == 28'd0) begin
               unique case (cnt_ff[3:0])
                  4'd0:  format_in[7:0]     = b;
                  4'd1:  format_in[15:8]    = b;
                  4'd2:  channels_in[7:0]   = b;
                  4'd3:  channels_in[15:8]  = b;
                  4'd4:  rate_in[7:0]       = b;
                  4'd5:  rate_in[15:8]      = b;
                  4'd6:  rate_in[23:16]     = b;
                  4'd7:  rate_in[31:24]     = b;
                  4'd8:  byte_rate_in[7:0]  = b;
                  4'd9:  byte_rate_in[15:8] = b;
                  4'd10: byte_rate_in[23:16] = b;
                  4'd11: byte_rate_in[31:24] = b;
                  4'd14: bits_in[7:0]       = b;
                  4'd15: bits_in[15:8]      = b;
                  default: begin
                  end
               endcase
            end
            cnt_in = cnt_inc;
            if (cnt_inc >= fmt_len_ff) begin
               phase_in = whp_pkg::PH_CKID;
               cnt_in   = '0;
               shift_in = '0;
            end
         end
         whp_pkg::PH_CKID: begin
            if (word_done) begin
               is_data_in = (word == whp_pkg::MAGIC_DATA);
               phase_in   = whp_pkg::PH_CKLEN;
               cnt_in     = '0;
               shift_in   = '0;
            end
         end
         whp_pkg::PH_CKLEN: begin
            if (word_done) begin
               if (is_data_ff) begin
                  result_valid         = 1'b1;
                  result.kind          = whp_pkg::KIND_FORMAT;
                  result.audio_format  = format_ff;
                  result.channel_count = channels_ff;
                  result.sample_rate   = rate_ff;
                  result.byte_rate     = byte_rate_ff;
                  result.sample_bits   = bits_ff;
                  result.payload_size  = word;
                  phase_in = (word == 32'd0) ? whp_pkg::PH_DONE : whp_pkg::PH_DATA;
               end else begin
                  phase_in = (word == 32'd0) ? whp_pkg::PH_CKID : whp_pkg::PH_SKIP;
               end
               cnt_in   = word;
               shift_in = '0;
            end
         end
         whp_pkg::PH_SKIP: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 32'd0) begin
               phase_in = whp_pkg::PH_CKID;
               shift_in = '0;
            end
         end
         whp_pkg::PH_DATA: begin
            cnt_in              = cnt_dec;
            result_valid        = 1'b1;
            result.kind         = whp_pkg::KIND_DATA;
            result.payload_byte = b;
            result.last_payload = (cnt_dec == 32'd0);
            if (cnt_dec == 32'd0) begin
               phase_in = whp_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase

      // end of stream: unfinished parse turns into an early-end error,
      // then every piece of state goes back to its reset value
      if (item.end_of_stream) begin
         if (phase_in != whp_pkg::PH_DONE && phase_in != whp_pkg::PH_ERROR) begin
            result_valid      = 1'b1;
            result            = '0;
            result.kind       = whp_pkg::KIND_ERROR;
            result.error_code = whp_pkg::ERR_EARLY_END;
         end
         phase_in     = whp_pkg::PH_RIFF;
         cnt_in       = '0;
         shift_in     = '0;
         fmt_len_in   = '0;
         format_in    = '0;
         channels_in  = '0;
         rate_in      = '0;
         byte_rate_in = '0;
         bits_in      = '0;
         is_data_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= whp_pkg::PH_RIFF;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         fmt_len_ff   <= '0;
         format_ff    <= '0;
         channels_ff  <= '0;
         rate_ff      <= '0;
         byte_rate_ff <= '0;
         bits_ff      <= '0;
         is_data_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         fmt_len_ff   <= fmt_len_in;
         format_ff    <= format_in;
         channels_ff  <= channels_in;
         rate_ff      <= rate_in;
         byte_rate_ff <= byte_rate_in;
         bits_ff      <= bits_in;
         is_data_ff   <= is_data_in;
      end
   end

endmodule

// ===== sv/whp_out_stage.sv =====
// ----------------------------------------------------------------------------
// WAV header parser result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module whp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  whp_pkg::rsp_item_type item,
   output logic                  can_load,
   whp_rsp_if.source             rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   whp_pkg::rsp_item_type item_ff;

   // free when empty or when the held item leaves this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = item_ff.kind;
   assign rsp_chan.payload_byte  = item_ff.payload_byte;
   assign rsp_chan.last_payload  = item_ff.last_payload;
   assign rsp_chan.audio_format  = item_ff.audio_format;
   assign rsp_chan.channel_count = item_ff.channel_count;
   assign rsp_chan.sample_rate   = item_ff.sample_rate;
   assign rsp_chan.byte_rate     = item_ff.byte_rate;
   assign rsp_chan.sample_bits   = item_ff.sample_bits;
   assign rsp_chan.payload_size  = item_ff.payload_size;
   assign rsp_chan.error_code    = item_ff.error_code;

endmodule

// ===== sv/wav_header_stream_parser_top.sv =====
// A byte item waits in the input register and steps the parser as it moves on; its
// result item then waits in the result register. Throughput: one byte item per cycle
// while the consumer keeps up. A result waiting on a stalled consumer holds the
// parser, so intake stops once the input register is full, even for bytes that
// give no result. Reset (synchronous, active high) empties both registers and
// returns the parser to waiting for the RIFF magic; no clearing pass is needed.
// ----------------------------------------------------------------------------
// WAV header stream parser, top level
// Byte-wide RIFF/WAVE parser: checks magic words, collects fmt fields, skips
// chunks up to data, then reports the format and passes the audio bytes.
// ----------------------------------------------------------------------------
module wav_header_stream_parser_top (
   input  logic      clock,
   input  logic      reset,
   whp_req_if.sink   req_chan,
   whp_rsp_if.source rsp_chan
);

   logic                  in_valid;
   whp_pkg::req_item_type in_item;
   logic                  out_free;
   logic                  step_en;
   logic                  result_valid;
   whp_pkg::rsp_item_type result;

   // advance the held byte whenever the result register can take its outcome;
   // bytes that give no result still advance and update the parse state
   assign step_en = in_valid && out_free;

   whp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (step_en),
      .item_valid (in_valid),
      .item       (in_item)
   );

   whp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (in_item),
      .result_valid (result_valid),
      .result       (result)
   );

   // load the result register only for bytes that produce an item
   whp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step_en && result_valid),
      .item     (result),
      .can_load (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV header stream parser testbench
// Streams whole and damaged RIFF/WAVE files into the parser one byte item at
// a time with random stalls on both channels. A byte-level predictor works
// out every expected result item and a checker compares each field.
// ----------------------------------------------------------------------------
module testbench;

   // Give up well beyond the slowest legal run: about 1200 byte items, each
   // with the longest input gap and the longest output stall.
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned RANDOM_BYTES = 1100;
   localparam int unsigned REPORT_LIMIT = 10;

   // How hard both channels idle while the current file is streamed
   typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_type;
   // Content of the format fields, chunk bodies and audio bytes
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   // -------------------------------------------------------------------------
   // Parser predictor and result checker
   // -------------------------------------------------------------------------
   class wav_parse_model;
      whp_pkg::phase_type    phase;
      logic [31:0]           count;
      logic [31:0]           word;
      logic [31:0]           fmt_len;
      logic [31:0]           rate;
      logic [31:0]           byte_rate;
      logic [15:0]           format;
      logic [15:0]           channels;
      logic [15:0]           bits;
      logic                  is_data;
      whp_pkg::rsp_item_type pending_results[$];
      int unsigned           mismatch_count;

      function new();
         clear();
         mismatch_count = 0;
      endfunction

      function void clear();
         phase     = whp_pkg::PH_RIFF;
         count     = '0;
         word      = '0;
         fmt_len   = '0;
         rate      = '0;
         byte_rate = '0;
         format    = '0;
         channels  = '0;
         bits      = '0;
         is_data   = 1'b0;
      endfunction

      // Collect a little-endian word; true once four bytes are in
      function bit gather(logic [7:0] b);
         word  = word | ({24'd0, b} << ((count & 32'd3) * 8));
         count = count + 1;
         return count >= 4;
      endfunction

      function void next_field(whp_pkg::phase_type p);
         phase = p;
         count = '0;
         word  = '0;
      endfunction

      function whp_pkg::rsp_item_type fault(whp_pkg::error_type code);
         whp_pkg::rsp_item_type r;
         r            = '0;
         r.kind       = whp_pkg::KIND_ERROR;
         r.error_code = code;
         phase        = whp_pkg::PH_ERROR;
         return r;
      endfunction

      // Advance the parse by one accepted byte item and queue its result
      function void take_byte(logic [7:0] b, logic eos);
         whp_pkg::rsp_item_type r;
         bit                    have;
         logic [31:0]           b32;
         r    = '0;
         have = 0;
         b32  = {24'd0, b};
         case (phase)
            whp_pkg::PH_RIFF: begin
               if (gather(b)) begin
                  if (word != whp_pkg::MAGIC_RIFF) begin
                     r    = fault(whp_pkg::ERR_BAD_RIFF);
                     have = 1;
                  end else begin
                     next_field(whp_pkg::PH_FSIZE);
                  end
               end
            end
            whp_pkg::PH_FSIZE: begin
               if (gather(b)) next_field(whp_pkg::PH_WAVE);
            end
            whp_pkg::PH_WAVE: begin
               if (gather(b)) begin
                  if (word != whp_pkg::MAGIC_WAVE) begin
                     r    = fault(whp_pkg::ERR_BAD_WAVE);
                     have = 1;
                  end else begin
                     next_field(whp_pkg::PH_FMTID);
                  end
               end
            end
            whp_pkg::PH_FMTID: begin
               if (gather(b)) begin
                  if (word != whp_pkg::MAGIC_FMT) begin
                     r    = fault(whp_pkg::ERR_BAD_FMT);
                     have = 1;
                  end else begin
                     next_field(whp_pkg::PH_FMTLEN);
                  end
               end
            end
            whp_pkg::PH_FMTLEN: begin
               if (gather(b)) begin
                  fmt_len = word;
                  if (fmt_len < whp_pkg::FMT_MIN_LEN) begin
                     r    = fault(whp_pkg::ERR_FMT_SHORT);
                     have = 1;
                  end else begin
                     next_field(whp_pkg::PH_FMTBODY);
                  end
               end
            end
            whp_pkg::PH_FMTBODY: begin
               if (count < 2) format = format | 16'(b32 << (count * 8));
               else if (count < 4) channels = channels | 16'(b32 << ((count - 2) * 8));
               else if (count < 8) rate = rate | (b32 << ((count - 4) * 8));
               else if (count < 12) byte_rate = byte_rate | (b32 << ((count - 8) * 8));
               else if (count >= 14 && count < 16) bits = bits | 16'(b32 << ((count - 14) * 8));
               count = count + 1;
               if (count >= fmt_len) next_field(whp_pkg::PH_CKID);
            end
            whp_pkg::PH_CKID: begin
               if (gather(b)) begin
                  is_data = (word == whp_pkg::MAGIC_DATA);
                  next_field(whp_pkg::PH_CKLEN);
               end
            end
            whp_pkg::PH_CKLEN: begin
               if (gather(b)) begin
                  if (is_data) begin
                     r.kind          = whp_pkg::KIND_FORMAT;
                     r.audio_format  = format;
                     r.channel_count = channels;
                     r.sample_rate   = rate;
                     r.byte_rate     = byte_rate;
                     r.sample_bits   = bits;
                     r.payload_size  = word;
                     have            = 1;
                     phase = (word == 0) ? whp_pkg::PH_DONE : whp_pkg::PH_DATA;
                  end else begin
                     phase = (word == 0) ? whp_pkg::PH_CKID : whp_pkg::PH_SKIP;
                  end
                  count = word;
                  word  = '0;
               end
            end
            whp_pkg::PH_SKIP: begin
               count = count - 1;
               if (count == 0) next_field(whp_pkg::PH_CKID);
            end
            whp_pkg::PH_DATA: begin
               count          = count - 1;
               r.kind         = whp_pkg::KIND_DATA;
               r.payload_byte = b;
               r.last_payload = (count == 0);
               have           = 1;
               if (count == 0) phase = whp_pkg::PH_DONE;
            end
            default: ;
         endcase
         if (eos) begin
            if (phase != whp_pkg::PH_DONE && phase != whp_pkg::PH_ERROR) begin
               r    = fault(whp_pkg::ERR_EARLY_END);
               have = 1;
            end
            clear();
         end
         if (have) pending_results.push_back(r);
      endfunction

      function string describe(whp_pkg::rsp_item_type r);
         return $sformatf({"kind=%0d byte=%02h last=%0d fmt=%04h ch=%04h rate=%08h",
                           " brate=%08h bits=%04h size=%08h err=%0d"},
                          r.kind, r.payload_byte, r.last_payload, r.audio_format,
                          r.channel_count, r.sample_rate, r.byte_rate, r.sample_bits,
                          r.payload_size, r.error_code);
      endfunction

      function void note_failure(string msg);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
      endfunction

      // Compare one accepted result item with the oldest expectation
      function void match_result(whp_pkg::rsp_item_type got);
         whp_pkg::rsp_item_type want;
         string                 diff;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result %s", describe(got)));
            return;
         end
         want = pending_results.pop_front();
         diff = "";
         if (got.kind !== want.kind) diff = {diff, " kind"};
         if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
         if (got.last_payload !== want.last_payload) diff = {diff, " last_payload"};
         if (got.audio_format !== want.audio_format) diff = {diff, " audio_format"};
         if (got.channel_count !== want.channel_count) diff = {diff, " channel_count"};
         if (got.sample_rate !== want.sample_rate) diff = {diff, " sample_rate"};
         if (got.byte_rate !== want.byte_rate) diff = {diff, " byte_rate"};
         if (got.sample_bits !== want.sample_bits) diff = {diff, " sample_bits"};
         if (got.payload_size !== want.payload_size) diff = {diff, " payload_size"};
         if (got.error_code !== want.error_code) diff = {diff, " error_code"};
         if (diff != "")
            note_failure($sformatf("mismatch in%s: expected %s, got %s",
                                   diff, describe(want), describe(got)));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block under test
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   whp_req_if req_chan ();
   whp_rsp_if rsp_chan ();

   wav_header_stream_parser_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wav_parse_model        parser;
   logic [7:0]            file_bytes[$];
   idle_type              idle_level = IDLE_LIGHT;
   fill_type              fill_mode = FILL_RANDOM;
   int unsigned           bytes_sent = 0;
   int unsigned           cycle_count = 0;
   whp_pkg::rsp_item_type seen_item;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Abort a hung run; the parser must never stall the stream this long
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Idle lengths: mostly none or short, now and then a long one
   // -------------------------------------------------------------------------
   function automatic int unsigned gap_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      case (idle_level)
         IDLE_NONE: return 0;
         IDLE_LIGHT: begin
            if (r < 75) return 0;
            if (r < 97) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
         end
         default: begin
            if (r < 40) return 0;
            if (r < 90) return $urandom_range(1, 4);
            return $urandom_range(10, 40);
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // File building
   // -------------------------------------------------------------------------
   function automatic logic [7:0] field_byte();
      case (fill_mode)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Append a word in file order, least significant byte first
   function automatic void add_word(logic [31:0] w);
      for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
   endfunction

   function automatic void add_fill(int unsigned n);
      repeat (n) file_bytes.push_back(field_byte());
   endfunction

   // Build a WAV file: header, fmt chunk of the given size, some unrelated
   // chunks, the data chunk and stray bytes after it. Huge sizes carry only a
   // bounded body, so such files always end early.
   function automatic void build_wav(logic [31:0] fmt_size, int unsigned others,
                                     logic [31:0] data_size, int unsigned trailing);
      int unsigned chunk_size;
      file_bytes.delete();
      add_word(whp_pkg::MAGIC_RIFF);
      add_word({field_byte(), field_byte(), field_byte(), field_byte()});
      add_word(whp_pkg::MAGIC_WAVE);
      add_word(whp_pkg::MAGIC_FMT);
      add_word(fmt_size);
      add_fill((fmt_size > 24) ? 24 : fmt_size);
      repeat (others) begin
         chunk_size = $urandom_range(0, 5);
         add_word($urandom());
         add_word(chunk_size);
         add_fill(chunk_size);
      end
      add_word(whp_pkg::MAGIC_DATA);
      add_word(data_size);
      add_fill((data_size > 64) ? 64 : data_size);
      add_fill(trailing);
   endfunction

   // Flip some bits of one byte
   function automatic void corrupt(int unsigned idx);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Offer one byte item; hold it until the parser takes it, then note it.
   // valid drops only across a gap, so it never toggles within one step.
   task automatic send_byte(logic [7:0] b, logic eos);
      int unsigned gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b;
      req_chan.end_of_stream <= eos;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      parser.take_byte(b, eos);
      bytes_sent++;
   endtask

   // Stream the first keep bytes of the file, end of stream on the last one
   task automatic send_file(int unsigned keep);
      for (int unsigned k = 0; k < keep; k++) send_byte(file_bytes[k], k == keep - 1);
   endtask

   // Result side: accept for one cycle, then stall for a random gap
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            stall_left = gap_cycles();
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Result monitor: values read here are the ones the edge itself saw
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_item.kind          = rsp_chan.kind;
         seen_item.payload_byte  = rsp_chan.payload_byte;
         seen_item.last_payload  = rsp_chan.last_payload;
         seen_item.audio_format  = rsp_chan.audio_format;
         seen_item.channel_count = rsp_chan.channel_count;
         seen_item.sample_rate   = rsp_chan.sample_rate;
         seen_item.byte_rate     = rsp_chan.byte_rate;
         seen_item.sample_bits   = rsp_chan.sample_bits;
         seen_item.payload_size  = rsp_chan.payload_size;
         seen_item.error_code    = rsp_chan.error_code;
         parser.match_result(seen_item);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned r;
      int unsigned shape;
      logic [31:0] fmt_size;
      logic [31:0] data_size;

      parser = new();
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= 8'h00;
      req_chan.end_of_stream <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed files first: clean file, all-zero and all-one fields,
      // padded fmt chunk with foreign chunks and bytes past the data
      build_wav(16, 0, 3, 0);
      send_file(file_bytes.size());
      fill_mode = FILL_ZERO;
      build_wav(16, 0, 1, 0);
      send_file(file_bytes.size());
      fill_mode = FILL_ONES;
      build_wav(16, 0, 2, 0);
      send_file(file_bytes.size());
      fill_mode = FILL_RANDOM;
      build_wav(18, 2, 2, 2);
      send_file(file_bytes.size());

      // Empty data chunk, ending on the size word and with stray bytes
      build_wav(16, 0, 0, 0);
      send_file(file_bytes.size());
      build_wav(16, 1, 0, 3);
      send_file(file_bytes.size());

      // Bad magic in each word, and a damaged size word that must not matter
      build_wav(16, 0, 2, 0);
      corrupt(0);
      send_file(file_bytes.size());
      build_wav(16, 0, 2, 0);
      corrupt(9);
      send_file(file_bytes.size());
      build_wav(16, 0, 2, 0);
      corrupt(14);
      send_file(file_bytes.size());
      build_wav(16, 0, 2, 0);
      corrupt(5);
      send_file(file_bytes.size());

      // fmt chunk too short
      build_wav(15, 0, 2, 0);
      send_file(file_bytes.size());
      build_wav(0, 0, 2, 0);
      send_file(file_bytes.size());

      // Stream ends early: in the data, on the first byte, in a huge data
      // chunk and in a huge fmt chunk
      build_wav(16, 0, 6, 0);
      send_file(file_bytes.size() - 3);
      build_wav(16, 0, 2, 0);
      send_file(1);
      build_wav(16, 0, 32'hFFFF_FFFF, 0);
      send_file(file_bytes.size());
      build_wav(32'hFFFF_FFF0, 0, 2, 0);
      send_file(30);

      // Random files: mostly well formed with random content, the rest
      // damaged, cut short or plain noise
      while (bytes_sent < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         idle_level = (r < 20) ? IDLE_NONE : (r < 75) ? IDLE_LIGHT : IDLE_HEAVY;
         r = $urandom_range(0, 99);
         fill_mode = (r < 5) ? FILL_ZERO : (r < 10) ? FILL_ONES : FILL_RANDOM;

         r = $urandom_range(0, 99);
         if (r < 75) fmt_size = 16;
         else if (r < 92) fmt_size = $urandom_range(17, 24);
         else if (r < 97) fmt_size = $urandom_range(0, 15);
         else fmt_size = $urandom();

         r = $urandom_range(0, 99);
         if (r < 80) data_size = $urandom_range(0, 12);
         else if (r < 95) data_size = $urandom_range(13, 40);
         else data_size = $urandom();

         r = $urandom_range(0, 99);
         build_wav(fmt_size, (r < 60) ? 0 : $urandom_range(1, 2), data_size,
                   ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 3));

         shape = $urandom_range(0, 99);
         if (shape < 70) begin
            send_file(file_bytes.size());
         end else if (shape < 82) begin
            // Hit the header words half the time, anything else otherwise
            if ($urandom_range(0, 1)) corrupt($urandom_range(0, 15));
            else corrupt($urandom_range(0, file_bytes.size() - 1));
            send_file(file_bytes.size());
         end else if (shape < 93) begin
            send_file($urandom_range(1, file_bytes.size()));
         end else begin
            fill_mode = FILL_RANDOM;
            file_bytes.delete();
            add_fill($urandom_range(1, 8));
            send_file(file_bytes.size());
         end
      end

      // Drain: drop valid, wait for every expected item, then keep the monitor
      // running so a spurious late result is still caught
      req_chan.valid <= 1'b0;
      idle_level = IDLE_NONE;
      while (parser.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (parser.pending_results.size() != 0)
         parser.note_failure("expected results never arrived");
      if (parser.mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/whp_pkg.sv
sv/whp_ifs.sv
sv/whp_in_stage.sv
sv/whp_parser.sv
sv/whp_out_stage.sv
sv/wav_header_stream_parser_top.sv
dv/testbench.sv
